[hdl/framed_parameter_link_engine_core_macros.svh]
// Assertion helpers for the link engine core
`ifndef FRAMED_PARAMETER_LINK_ENGINE_CORE_MACROS_SVH
`define FRAMED_PARAMETER_LINK_ENGINE_CORE_MACROS_SVH
`ifndef SYNTH
`define FPLE_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FPLE_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FPLE_ASSERT_IMP(name, ante, cons)
`define FPLE_ASSERT_NXT(name, ante, cons)
`endif
`endif

[hdl/fple_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fple_pkg;

    localparam int MAX_PAYLOAD_DEF = 16;
    localparam int NUM_PARAMS_DEF  = 6;
    localparam int PL_USED         = 6;

    localparam logic [7:0] START_BYTE = 8'hAB;
    localparam logic [7:0] DST_BYTE   = 8'hFF;
    localparam logic [7:0] SRC_BYTE   = 8'hFE;
    localparam logic [7:0] FN_CMD     = 8'hE0;
    localparam logic [7:0] FN_WRITE   = 8'hE1;
    localparam logic [7:0] FN_NAME    = 8'hE2;
    localparam logic [7:0] FN_INFO    = 8'hE3;
    localparam logic [7:0] FN_ACK     = 8'h00;
    localparam logic [7:0] CMD_INFO   = 8'h00;
    localparam logic [7:0] CMD_COUNT  = 8'h01;
    localparam logic [7:0] CMD_READ   = 8'h02;
    localparam logic [7:0] CMD_NAME   = 8'h03;
    localparam logic [7:0] CMD_SAVE   = 8'h10;
    localparam logic [7:0] PARAM_TYPE = 8'h08;

    localparam logic [1:0] CFG_MAX_LEN = 2'd0;
    localparam logic [1:0] CFG_NAME    = 2'd1;
    localparam logic [4:0] MAX_LEN_RST = 5'd10;
    localparam logic [7:0] NAME_RST    = 8'd88;

    typedef enum logic [3:0] {
        ST_START, ST_SRC, ST_DST, ST_FUNC, ST_LEN_LO, ST_LEN_HI,
        ST_PAYLOAD, ST_SUM, ST_ADD, ST_TX
    } state_t;

    typedef enum logic [2:0] {
        RP_NONE, RP_INFO, RP_COUNT, RP_READ, RP_NAME, RP_SAVE, RP_WRITE
    } reply_t;

    typedef struct packed {
        logic take;
        logic start;
        logic accum;
        logic func_wr;
        logic len_lo_wr;
        logic len_hi_wr;
        logic pay_wr;
        logic sum_wr;
        logic exec;
        logic tx_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_start;
        logic len_ok;
        logic len_zero;
        logic pay_last;
        logic reply_go;
        logic load_ok;
        logic tx_last;
    } dp_status_t;

    function automatic logic [4:0] reply_len(reply_t k);
        case (k)
            RP_INFO:  reply_len = 5'd10;
            RP_READ:  reply_len = 5'd6;
            RP_NAME:  reply_len = 5'd23;
            RP_NONE:  reply_len = 5'd0;
            default:  reply_len = 5'd3;
        endcase
    endfunction

    function automatic logic [7:0] reply_func(reply_t k);
        case (k)
            RP_INFO:  reply_func = FN_INFO;
            RP_COUNT: reply_func = FN_CMD;
            RP_READ:  reply_func = FN_WRITE;
            RP_NAME:  reply_func = FN_NAME;
            default:  reply_func = FN_ACK;
        endcase
    endfunction

    function automatic logic [7:0] name_char(logic [7:0] id, logic [1:0] pos);
        logic [7:0] c0;
        logic [7:0] c2;
        c0 = (id < 8'd3) ? "S" : "L";
        c2 = (id == 8'd0 || id == 8'd3) ? "P" : (id == 8'd1 || id == 8'd4) ? "I" : "D";
        if (id >= 8'd6)
            name_char = 8'h00;
        else
        begin
            case (pos)
                2'd0:    name_char = c0;
                2'd1:    name_char = (id < 8'd3) ? "E" : "M";
                2'd2:    name_char = c2;
                default: name_char = 8'h00;
            endcase
        end
    endfunction

endpackage
`default_nettype wire

[hdl/fple_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module fple_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire fple_pkg::dp_status_t status,
    output fple_pkg::ctrl_cmd_t     cmd
);

    fple_pkg::state_t state_reg;
    fple_pkg::state_t state_next;
    logic             take;

    assign take = in_valid && (state_reg != fple_pkg::ST_TX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= fple_pkg::ST_START;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fple_pkg::ST_START:   if (take && status.is_start) state_next = fple_pkg::ST_SRC;
            fple_pkg::ST_SRC:     if (take) state_next = fple_pkg::ST_DST;
            fple_pkg::ST_DST:     if (take) state_next = fple_pkg::ST_FUNC;
            fple_pkg::ST_FUNC:    if (take) state_next = fple_pkg::ST_LEN_LO;
            fple_pkg::ST_LEN_LO:  if (take) state_next = fple_pkg::ST_LEN_HI;
            fple_pkg::ST_LEN_HI:
                if (take)
                begin
                    if (!status.len_ok)
                        state_next = fple_pkg::ST_START;
                    else if (status.len_zero)
                        state_next = fple_pkg::ST_SUM;
                    else
                        state_next = fple_pkg::ST_PAYLOAD;
                end
            fple_pkg::ST_PAYLOAD: if (take && status.pay_last) state_next = fple_pkg::ST_SUM;
            fple_pkg::ST_SUM:     if (take) state_next = fple_pkg::ST_ADD;
            fple_pkg::ST_ADD:
                if (take)
                    state_next = status.reply_go ? fple_pkg::ST_TX : fple_pkg::ST_START;
            fple_pkg::ST_TX:
                if (status.load_ok && status.tx_last) state_next = fple_pkg::ST_START;
            default:              state_next = fple_pkg::ST_START;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.take = take;
        in_stall = (state_reg == fple_pkg::ST_TX);
        case (state_reg)
            fple_pkg::ST_START:   cmd.start = take && status.is_start;
            fple_pkg::ST_SRC,
            fple_pkg::ST_DST:     cmd.accum = take;
            fple_pkg::ST_FUNC:
            begin
                cmd.accum   = take;
                cmd.func_wr = take;
            end
            fple_pkg::ST_LEN_LO:
            begin
                cmd.accum     = take;
                cmd.len_lo_wr = take;
            end
            fple_pkg::ST_LEN_HI:
            begin
                cmd.accum     = take;
                cmd.len_hi_wr = take;
            end
            fple_pkg::ST_PAYLOAD:
            begin
                cmd.accum  = take;
                cmd.pay_wr = take;
            end
            fple_pkg::ST_SUM:     cmd.sum_wr = take;
            fple_pkg::ST_ADD:     cmd.exec = take && status.reply_go;
            fple_pkg::ST_TX:      cmd.tx_load = status.load_ok;
            default:              cmd.take = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

[hdl/fple_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module fple_dp #(
    parameter int MAX_PAYLOAD = fple_pkg::MAX_PAYLOAD_DEF,
    parameter int NUM_PARAMS  = fple_pkg::NUM_PARAMS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic [7:0]         rx_byte,
    input  wire logic               out_stall,
    input  wire fple_pkg::ctrl_cmd_t cmd,
    output fple_pkg::dp_status_t    status,
    output logic                    out_valid,
    output logic [7:0]              tx_byte,
    output logic                    tx_last,
    output logic                    param_written,
    output logic [2:0]              param_index,
    output logic [31:0]             param_value,
    output logic                    save_request
);

    localparam int LW  = $clog2(MAX_PAYLOAD + 1);
    localparam int IDW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;

    logic [4:0]       max_len_reg;
    logic [7:0]       name_reg;
    logic [7:0]       func_reg;
    logic [7:0]       len_lo_reg;
    logic [LW-1:0]    len_reg;
    logic [LW-1:0]    cnt_reg;
    logic [7:0]       pl_reg [fple_pkg::PL_USED];
    logic [7:0]       sum_reg;
    logic [7:0]       add_reg;
    logic [7:0]       rsum_reg;
    logic [31:0]      table_reg [NUM_PARAMS];
    fple_pkg::reply_t kind_reg;
    fple_pkg::reply_t kind_next;
    logic [7:0]       addb_reg;
    logic [4:0]       idx_reg;
    logic [7:0]       tsum_reg;
    logic [7:0]       tadd_reg;
    logic             ovalid_reg;
    logic [7:0]       obyte_reg;
    logic             olast_reg;
    logic             owr_reg;
    logic [2:0]       oidx_reg;
    logic [31:0]      oval_reg;
    logic             osave_reg;

    logic [7:0]  pay [fple_pkg::PL_USED];
    logic [15:0] len16;
    logic [15:0] lim16;
    logic [LW:0] cnt_inc;
    logic [15:0] e0_id;
    logic [15:0] e1_id;
    logic [15:0] id16;
    logic [IDW-1:0] id_sel;
    logic [31:0] wval;
    logic [31:0] rval;
    logic [4:0]  n;
    logic [4:0]  k;
    logic [7:0]  pbyte;
    logic [7:0]  byte_now;
    logic [7:0]  sum_now;
    logic [7:0]  sum_acc;

    always_comb
    begin
        for (int i = 0; i < fple_pkg::PL_USED; i++)
            pay[i] = (LW'(i) < len_reg) ? pl_reg[i] : 8'h00;
    end

    assign len16   = {rx_byte, len_lo_reg};
    assign lim16   = ({11'b0, max_len_reg} > 16'(MAX_PAYLOAD)) ? 16'(MAX_PAYLOAD)
                                                              : {11'b0, max_len_reg};
    assign cnt_inc = {1'b0, cnt_reg} + 1'b1;
    assign e0_id   = {pay[2], pay[1]};
    assign e1_id   = {pay[1], pay[0]};
    assign wval    = {pay[5], pay[4], pay[3], pay[2]};
    assign id16    = (kind_reg == fple_pkg::RP_WRITE) ? e1_id : e0_id;
    assign id_sel  = IDW'(id16);
    assign rval    = (id16 < 16'(NUM_PARAMS)) ? table_reg[id_sel] : 32'h0;
    assign sum_now = sum_reg + rx_byte;

    // classify the frame from its function code and first payload bytes
    always_comb
    begin
        kind_next = fple_pkg::RP_NONE;
        if (func_reg == fple_pkg::FN_CMD)
        begin
            case (pay[0])
                fple_pkg::CMD_INFO:  kind_next = fple_pkg::RP_INFO;
                fple_pkg::CMD_COUNT: kind_next = fple_pkg::RP_COUNT;
                fple_pkg::CMD_READ:
                    if (e0_id < 16'(NUM_PARAMS)) kind_next = fple_pkg::RP_READ;
                fple_pkg::CMD_NAME:
                    if (e0_id < 16'(NUM_PARAMS)) kind_next = fple_pkg::RP_NAME;
                fple_pkg::CMD_SAVE:  kind_next = fple_pkg::RP_SAVE;
                default:             kind_next = fple_pkg::RP_NONE;
            endcase
        end
        else if (func_reg == fple_pkg::FN_WRITE && e1_id < 16'(NUM_PARAMS))
            kind_next = fple_pkg::RP_WRITE;
    end

    assign n = fple_pkg::reply_len(kind_reg);
    assign k = idx_reg - 5'd6;

    always_comb
    begin
        pbyte = 8'h00;
        case (kind_reg)
            fple_pkg::RP_INFO:
                if (k == 5'd0) pbyte = fple_pkg::DST_BYTE;
                else if (k == 5'd9) pbyte = name_reg;
            fple_pkg::RP_COUNT:
                case (k)
                    5'd0:    pbyte = 8'h01;
                    5'd1:    pbyte = 8'(NUM_PARAMS);
                    5'd2:    pbyte = 8'(NUM_PARAMS >> 8);
                    default: pbyte = 8'h00;
                endcase
            fple_pkg::RP_READ:
                case (k)
                    5'd0:    pbyte = id16[7:0];
                    5'd1:    pbyte = id16[15:8];
                    5'd2:    pbyte = rval[7:0];
                    5'd3:    pbyte = rval[15:8];
                    5'd4:    pbyte = rval[23:16];
                    5'd5:    pbyte = rval[31:24];
                    default: pbyte = 8'h00;
                endcase
            fple_pkg::RP_NAME:
                case (k)
                    5'd0:    pbyte = id16[7:0];
                    5'd1:    pbyte = id16[15:8];
                    5'd2:    pbyte = fple_pkg::PARAM_TYPE;
                    5'd3:    pbyte = fple_pkg::name_char(id16[7:0], 2'd0);
                    5'd4:    pbyte = fple_pkg::name_char(id16[7:0], 2'd1);
                    5'd5:    pbyte = fple_pkg::name_char(id16[7:0], 2'd2);
                    default: pbyte = 8'h00;
                endcase
            fple_pkg::RP_SAVE,
            fple_pkg::RP_WRITE:
                case (k)
                    5'd0:    pbyte = (kind_reg == fple_pkg::RP_SAVE) ? fple_pkg::FN_CMD
                                                                     : fple_pkg::FN_WRITE;
                    5'd1:    pbyte = rsum_reg;
                    5'd2:    pbyte = addb_reg;
                    default: pbyte = 8'h00;
                endcase
            default: pbyte = 8'h00;
        endcase
    end

    always_comb
    begin
        case (idx_reg)
            5'd0:    byte_now = fple_pkg::START_BYTE;
            5'd1:    byte_now = fple_pkg::DST_BYTE;
            5'd2:    byte_now = fple_pkg::SRC_BYTE;
            5'd3:    byte_now = fple_pkg::reply_func(kind_reg);
            5'd4:    byte_now = {3'b0, n};
            5'd5:    byte_now = 8'h00;
            default:
                if (idx_reg < n + 5'd6)
                    byte_now = pbyte;
                else if (idx_reg == n + 5'd6)
                    byte_now = tsum_reg;
                else
                    byte_now = tadd_reg;
        endcase
    end

    assign sum_acc = tsum_reg + byte_now;

    assign status.is_start = (rx_byte == fple_pkg::START_BYTE);
    assign status.len_ok   = (len16 <= lim16);
    assign status.len_zero = (len16 == 16'h0);
    assign status.pay_last = (cnt_inc >= {1'b0, len_reg});
    assign status.reply_go = (rsum_reg == sum_reg) && (rx_byte == add_reg)
                             && (kind_next != fple_pkg::RP_NONE);
    assign status.load_ok  = !ovalid_reg || !out_stall;
    assign status.tx_last  = (idx_reg == n + 5'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg <= fple_pkg::MAX_LEN_RST;
            name_reg    <= fple_pkg::NAME_RST;
            func_reg    <= '0;
            len_lo_reg  <= '0;
            len_reg     <= '0;
            cnt_reg     <= '0;
            sum_reg     <= '0;
            add_reg     <= '0;
            rsum_reg    <= '0;
            kind_reg    <= fple_pkg::RP_NONE;
            addb_reg    <= '0;
            idx_reg     <= '0;
            tsum_reg    <= '0;
            tadd_reg    <= '0;
            ovalid_reg  <= 1'b0;
            for (int i = 0; i < NUM_PARAMS; i++)
                table_reg[i] <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == fple_pkg::CFG_MAX_LEN)
                max_len_reg <= cfg_data[4:0];
            if (cfg_we && cfg_index == fple_pkg::CFG_NAME)
                name_reg <= cfg_data;
            if (cmd.start)
            begin
                sum_reg <= rx_byte;
                add_reg <= rx_byte;
                len_reg <= '0;
            end
            else if (cmd.accum)
            begin
                sum_reg <= sum_now;
                add_reg <= add_reg + sum_now;
            end
            if (cmd.func_wr)
                func_reg <= rx_byte;
            if (cmd.len_lo_wr)
                len_lo_reg <= rx_byte;
            if (cmd.len_hi_wr)
            begin
                cnt_reg <= '0;
                if (status.len_ok)
                    len_reg <= LW'(len16);
            end
            if (cmd.pay_wr)
                cnt_reg <= cnt_inc[LW-1:0];
            if (cmd.sum_wr)
                rsum_reg <= rx_byte;
            if (cmd.exec)
            begin
                kind_reg <= kind_next;
                addb_reg <= rx_byte;
                idx_reg  <= '0;
                tsum_reg <= '0;
                tadd_reg <= '0;
                if (kind_next == fple_pkg::RP_WRITE)
                    table_reg[IDW'(e1_id)] <= wval;
            end
            // hold the beat while stalled, advance on each load
            if (cmd.tx_load)
            begin
                ovalid_reg <= 1'b1;
                idx_reg    <= idx_reg + 5'd1;
                // keep the check bytes out of the running checks
                if (idx_reg < n + 5'd6)
                begin
                    tsum_reg <= sum_acc;
                    tadd_reg <= tadd_reg + sum_acc;
                end
            end
            else if (!out_stall)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pay_wr && cnt_reg < LW'(fple_pkg::PL_USED))
            pl_reg[cnt_reg[$clog2(fple_pkg::PL_USED)-1:0]] <= rx_byte;
        if (cmd.tx_load)
        begin
            obyte_reg <= byte_now;
            olast_reg <= status.tx_last;
            owr_reg   <= (kind_reg == fple_pkg::RP_WRITE);
            oidx_reg  <= (kind_reg == fple_pkg::RP_WRITE) ? e1_id[2:0] : 3'd0;
            oval_reg  <= (kind_reg == fple_pkg::RP_WRITE) ? wval : 32'h0;
            osave_reg <= (kind_reg == fple_pkg::RP_SAVE);
        end
    end

    assign out_valid     = ovalid_reg;
    assign tx_byte       = obyte_reg;
    assign tx_last       = olast_reg;
    assign param_written = owr_reg;
    assign param_index   = oidx_reg;
    assign param_value   = oval_reg;
    assign save_request  = osave_reg;

endmodule
`default_nettype wire

[hdl/framed_parameter_link_engine_core.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "framed_parameter_link_engine_core_macros.svh"
// Receives link bytes, checks 0xAB-framed requests by their sum and add bytes,
// and answers parameter commands with reply frames of 11 to 31 bytes. Each
// received byte is taken while in_valid is high and the receive side is not
// stalled. After a valid request the frame sequencer emits its reply at one
// byte per cycle (stall permitting) and holds the receive side stalled until
// its last reply byte is loaded. Parameter words reset to zero.
module framed_parameter_link_engine_core #(
    parameter int MAX_PAYLOAD = fple_pkg::MAX_PAYLOAD_DEF,
    parameter int NUM_PARAMS  = fple_pkg::NUM_PARAMS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       tx_byte,
    output logic             tx_last,
    output logic             param_written,
    output logic [2:0]       param_index,
    output logic [31:0]      param_value,
    output logic             save_request
);

    fple_pkg::ctrl_cmd_t  cmd;
    fple_pkg::dp_status_t status;

    fple_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fple_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .NUM_PARAMS  (NUM_PARAMS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .rx_byte       (rx_byte),
        .out_stall     (out_stall),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .tx_byte       (tx_byte),
        .tx_last       (tx_last),
        .param_written (param_written),
        .param_index   (param_index),
        .param_value   (param_value),
        .save_request  (save_request)
    );

    `FPLE_ASSERT_NXT(a_tx_end_frees_rx, cmd.tx_load && status.tx_last, !in_stall)
    `FPLE_ASSERT_IMP(a_no_rx_during_tx, in_stall, !cmd.take)
    `FPLE_ASSERT_IMP(a_write_not_save, out_valid && param_written, !save_request)

endmodule
`default_nettype wire
